### rtl/balist_pkg.sv
`default_nettype none

package balist_pkg;

   // Operation codes carried on req_func.
   typedef enum logic [1:0] {
      FUNC_GET    = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_INSERT = 2'd2,
      FUNC_ERASE  = 2'd3
   } func_type;

   // Result status codes carried on rsp_status.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Field widths fixed by the port definition.
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // Control from the sequencer to the index walker.
   typedef struct packed {
      logic load;   // take a new start index, last index and direction
      logic step;   // issue a read at the current index and advance
      logic up;     // walk toward higher indexes
   } walk_ctrl_type;

   // Status from the index walker back to the sequencer.
   typedef struct packed {
      logic pend;     // read data for prv_idx is on the memory output
      logic at_last;  // current index is the last one of the walk
      logic match;    // memory output equals the search key
   } walk_stat_type;

endpackage

`default_nettype wire

### rtl/bounded_array_list.sv
// Channel   Ports                                            Handshake
// request   req_func, req_position, req_item_value           req_start while busy is low
// response  rsp_status, rsp_read_value, rsp_hit,             rsp_valid, one cycle
//           rsp_hit_index, rsp_count_after
//
// Errors, a search of an empty list and an erase of the last entry answer
// in the cycle after the request. The memory, with one write port and one
// registered read port, is walked one entry per cycle. Reset clears the
// count and the sequencer, not the memory. The response lasts one cycle
// and cannot be held off.
`default_nettype none

module bounded_array_list #(
   parameter int CAPACITY = 64,
   parameter int DATA_W   = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_func,
   input  wire logic [balist_pkg::POS_W-1:0]        req_position,
   input  wire logic [balist_pkg::VALUE_W-1:0]      req_item_value,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic [balist_pkg::VALUE_W-1:0]           rsp_read_value,
   output logic                                     rsp_hit,
   output logic [balist_pkg::POS_W-1:0]             rsp_hit_index,
   output logic [balist_pkg::COUNT_W-1:0]           rsp_count_after
);

   import balist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DRAIN, ST_PUT} state_type;

   state_type           state_ff;
   func_type            op_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [DATA_W-1:0]   key_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_read_value_ff;
   logic                rsp_hit_ff;
   logic [POS_W-1:0]    rsp_hit_index_ff;
   logic [COUNT_W-1:0]  rsp_count_after_ff;

   func_type            req_op;
   logic                accept;
   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    cnt_cmp;
   logic [CNT_W-1:0]    cnt_m1;
   logic [CNT_W-1:0]    cnt_p1;
   logic [IDX_W-1:0]    req_idx;
   logic [DATA_W-1:0]   req_key;
   logic                in_range;
   logic                ins_range;
   logic                is_full;
   logic                is_tail;

   walk_ctrl_type       wctrl;
   walk_stat_type       wstat;
   logic [IDX_W-1:0]    start_idx;
   logic [IDX_W-1:0]    last_idx;
   logic [IDX_W-1:0]    cur_idx;
   logic [IDX_W-1:0]    prv_idx;
   logic [IDX_W-1:0]    adj_idx;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [DATA_W-1:0]   mem_wd;
   logic [DATA_W-1:0]   mem_rd;

   // Request decode and the range checks made when a request is taken.
   assign accept    = req_start & (state_ff == ST_IDLE);
   assign req_op    = func_type'(req_func);
   assign req_idx   = IDX_W'(req_position);
   assign req_key   = DATA_W'(req_item_value);
   assign pos_cmp   = CMP_W'(req_position);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign cnt_p1    = count_ff + CNT_W'(1);
   assign in_range  = (pos_cmp < cnt_cmp);
   assign ins_range = (pos_cmp <= cnt_cmp);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_tail   = (pos_cmp == CMP_W'(cnt_m1));

   // Walk setup: search and erase go up through the list, insert goes down
   // from the last entry to the insert position.
   always_comb begin
      wctrl.load = accept;
      wctrl.step = (state_ff == ST_READ);
      wctrl.up   = 1'b1;
      start_idx  = req_idx;
      last_idx   = req_idx;
      case (req_op)
         FUNC_GET: begin
            start_idx = req_idx;
            last_idx  = req_idx;
         end
         FUNC_SEARCH: begin
            start_idx = '0;
            last_idx  = IDX_W'(cnt_m1);
         end
         FUNC_INSERT: begin
            wctrl.up  = 1'b0;
            start_idx = IDX_W'(cnt_m1);
            last_idx  = req_idx;
         end
         FUNC_ERASE: begin
            start_idx = req_idx + IDX_W'(1);
            last_idx  = IDX_W'(cnt_m1);
         end
         default: begin
            start_idx = req_idx;
            last_idx  = req_idx;
         end
      endcase
   end

   // Memory write: shifted entries while walking, the new word at the end
   // of an insert.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = adj_idx;
      mem_wd = mem_rd;
      if ((state_ff == ST_READ || state_ff == ST_DRAIN) && wstat.pend &&
          (op_ff == FUNC_INSERT || op_ff == FUNC_ERASE)) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_PUT) begin
         mem_we = 1'b1;
         mem_wa = pos_ff;
         mem_wd = key_ff;
      end
   end

   balist_mem #(
      .DEPTH (CAPACITY),
      .AW    (IDX_W),
      .DW    (DATA_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (cur_idx),
      .rd_data (mem_rd)
   );

   balist_walk #(
      .IDX_W  (IDX_W),
      .DATA_W (DATA_W)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (wctrl),
      .start_idx (start_idx),
      .last_idx  (last_idx),
      .rd_data   (mem_rd),
      .key       (key_ff),
      .cur_idx   (cur_idx),
      .prv_idx   (prv_idx),
      .adj_idx   (adj_idx),
      .stat      (wstat)
   );

   // Sequencer with the count and the response word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff              <= req_op;
                  pos_ff             <= req_idx;
                  key_ff             <= req_key;
                  rsp_status_ff      <= STAT_OK;
                  rsp_read_value_ff  <= '0;
                  rsp_hit_ff         <= 1'b0;
                  rsp_hit_index_ff   <= '0;
                  rsp_count_after_ff <= COUNT_W'(count_ff);
                  case (req_op)
                     FUNC_GET: begin
                        if (in_range) begin
                           state_ff <= ST_READ;
                        end else begin
                           rsp_status_ff <= STAT_RANGE;
                           rsp_valid_ff  <= 1'b1;
                        end
                     end
                     FUNC_SEARCH: begin
                        if (count_ff != '0) begin
                           state_ff <= ST_READ;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     FUNC_INSERT: begin
                        if (!ins_range) begin
                           rsp_status_ff <= STAT_RANGE;
                           rsp_valid_ff  <= 1'b1;
                        end else if (is_full) begin
                           rsp_status_ff <= STAT_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else if (pos_cmp == cnt_cmp) begin
                           state_ff <= ST_PUT;
                        end else begin
                           state_ff <= ST_READ;
                        end
                     end
                     FUNC_ERASE: begin
                        if (!in_range) begin
                           rsp_status_ff <= STAT_RANGE;
                           rsp_valid_ff  <= 1'b1;
                        end else if (is_tail) begin
                           count_ff           <= cnt_m1;
                           rsp_count_after_ff <= COUNT_W'(cnt_m1);
                           rsp_valid_ff       <= 1'b1;
                        end else begin
                           state_ff <= ST_READ;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               // A search stops at the first matching entry.
               if (op_ff == FUNC_SEARCH && wstat.pend && wstat.match) begin
                  rsp_hit_ff       <= 1'b1;
                  rsp_hit_index_ff <= POS_W'(prv_idx);
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= ST_IDLE;
               end else if (wstat.at_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // The data of the last read is on the memory output now.
               case (op_ff)
                  FUNC_GET: begin
                     rsp_read_value_ff <= VALUE_W'(mem_rd);
                     rsp_valid_ff      <= 1'b1;
                     state_ff          <= ST_IDLE;
                  end
                  FUNC_SEARCH: begin
                     rsp_hit_ff       <= wstat.match;
                     rsp_hit_index_ff <= wstat.match ? POS_W'(prv_idx) : '0;
                     rsp_valid_ff     <= 1'b1;
                     state_ff         <= ST_IDLE;
                  end
                  FUNC_INSERT: begin
                     state_ff <= ST_PUT;
                  end
                  FUNC_ERASE: begin
                     count_ff           <= cnt_m1;
                     rsp_count_after_ff <= COUNT_W'(cnt_m1);
                     rsp_valid_ff       <= 1'b1;
                     state_ff           <= ST_IDLE;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_PUT: begin
               count_ff           <= cnt_p1;
               rsp_count_after_ff <= COUNT_W'(cnt_p1);
               rsp_valid_ff       <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_index   = rsp_hit_index_ff;
   assign rsp_count_after = rsp_count_after_ff;

`ifndef SYNTH
   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A taken request either starts a walk or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("request taken without progress");

   // A full error is only reported when the list is at capacity.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> is_full)
      else $error("full status with room left");

   // The final write of an insert always produces the response next.
   a_put_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |=> (rsp_valid && !busy))
      else $error("insert did not complete");
`endif

endmodule

`default_nettype wire

### rtl/balist_mem.sv
`default_nettype none

module balist_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/balist_walk.sv
`default_nettype none

module balist_walk #(
   parameter int IDX_W  = 6,
   parameter int DATA_W = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire balist_pkg::walk_ctrl_type ctrl,
   input  wire logic [IDX_W-1:0]          start_idx,
   input  wire logic [IDX_W-1:0]          last_idx,
   input  wire logic [DATA_W-1:0]         rd_data,
   input  wire logic [DATA_W-1:0]         key,
   output logic      [IDX_W-1:0]          cur_idx,
   output logic      [IDX_W-1:0]          prv_idx,
   output logic      [IDX_W-1:0]          adj_idx,
   output balist_pkg::walk_stat_type      stat
);

   import balist_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] last_ff;
   logic [IDX_W-1:0] prv_ff;
   logic             up_ff;
   logic             pend_ff;

   // The index moves one entry per read; the previous index follows it so
   // that the data coming out of the memory can be matched to its address.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctrl.step & ~ctrl.load;
      end
      if (ctrl.load) begin
         idx_ff  <= start_idx;
         last_ff <= last_idx;
         up_ff   <= ctrl.up;
      end else if (ctrl.step) begin
         prv_ff <= idx_ff;
         idx_ff <= up_ff ? idx_ff + IDX_W'(1) : idx_ff - IDX_W'(1);
      end
   end

   // Shifting writes land next to the entry just read: one below when the
   // walk goes up (erase), one above when it goes down (insert).
   assign adj_idx      = up_ff ? prv_ff - IDX_W'(1) : prv_ff + IDX_W'(1);
   assign cur_idx      = idx_ff;
   assign prv_idx      = prv_ff;
   assign stat.pend    = pend_ff;
   assign stat.at_last = (idx_ff == last_ff);
   assign stat.match   = (rd_data == key);

endmodule

`default_nettype wire
